// ----- hw/rtl/jsu_pkg.sv -----
package jsu_pkg;

    // Default depth of the request queue between front and back.
    localparam int FIFO_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX1,
        PH_PAIR_BS,
        PH_PAIR_U,
        PH_HEX2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_ERR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
        logic       input_ends;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } out_item_t;

    // One queued request: up to four result bytes, index of the last one, kind.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        kind_t           kind;
    } pkt_t;

endpackage

// ----- hw/rtl/jsu_stream_if.sv -----
interface jsu_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/jsu_front.sv -----
module jsu_front
    import jsu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsu_stream_if.sink   in_ch,
    input  logic         q_full,
    output logic         push,
    output pkt_t         push_pkt
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [5:0] SUR_HI    = 6'b110110;  // 0xd800..0xdbff
    localparam logic [5:0] SUR_LO    = 6'b110111;  // 0xdc00..0xdfff

    // {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                r = {1'b1, 4'(c - 8'h30)};
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                r = {1'b1, 4'(c - 8'h57)};
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                r = {1'b1, 4'(c - 8'h37)};
            end
            return r;
        end
    endfunction

    function automatic pkt_t utf8_enc(input logic [20:0] cp);
        pkt_t p;
        begin
            p      = '0;
            p.kind = KIND_DATA;
            if (cp <= 21'h7f)
            begin
                p.bytes[0] = cp[7:0];
                p.last_idx = 2'd0;
            end
            else if (cp <= 21'h7ff)
            begin
                p.bytes[0] = {3'b110, cp[10:6]};
                p.bytes[1] = {2'b10, cp[5:0]};
                p.last_idx = 2'd1;
            end
            else if (cp <= 21'hffff)
            begin
                p.bytes[0] = {4'b1110, cp[15:12]};
                p.bytes[1] = {2'b10, cp[11:6]};
                p.bytes[2] = {2'b10, cp[5:0]};
                p.last_idx = 2'd2;
            end
            else
            begin
                p.bytes[0] = {5'b11110, cp[20:18]};
                p.bytes[1] = {2'b10, cp[17:12]};
                p.bytes[2] = {2'b10, cp[11:6]};
                p.bytes[3] = {2'b10, cp[5:0]};
                p.last_idx = 2'd3;
            end
            return p;
        end
    endfunction

    phase_t      phase_reg, phase_next;
    logic [15:0] hex_reg, hex_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [9:0]  hsur_reg, hsur_next;

    logic        acc;
    logic [7:0]  c;
    logic [4:0]  dig;
    logic [15:0] hex_new;
    logic        hex_done;
    logic [20:0] cp_pair;
    logic        err;
    logic        close;
    logic        has_data;
    pkt_t        data_pkt;

    assign in_ch.ready = !q_full;
    assign acc         = in_ch.valid && in_ch.ready;
    assign c           = in_ch.data.in_byte;
    assign dig         = hex_digit(c);
    assign hex_new     = {hex_reg[11:0], dig[3:0]};
    assign hex_done    = (hcnt_reg == 2'd3);
    assign cp_pair     = {({1'b0, hsur_reg} + 11'h040), hex_new[9:0]};

    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        hcnt_next  = hcnt_reg;
        hsur_next  = hsur_reg;
        err        = 1'b0;
        close      = 1'b0;
        has_data   = 1'b0;
        data_pkt   = '0;
        data_pkt.kind = KIND_DATA;

        if (in_ch.data.start_req)
        begin
            hex_next  = '0;
            hcnt_next = '0;
            hsur_next = '0;
            if (c == CH_QUOTE)
            begin
                phase_next = PH_STR;
            end
            else
            begin
                err = 1'b1;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_STR:
                begin
                    if (c == CH_QUOTE)
                    begin
                        close = 1'b1;
                    end
                    else if (c < CH_SPACE)
                    begin
                        err = 1'b1;
                    end
                    else if (c == CH_BSLASH)
                    begin
                        phase_next = PH_ESC;
                    end
                    else
                    begin
                        has_data          = 1'b1;
                        data_pkt.bytes[0] = c;
                    end
                end
                PH_ESC:
                begin
                    phase_next = PH_STR;
                    has_data   = 1'b1;
                    if (c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH)
                    begin
                        data_pkt.bytes[0] = c;
                    end
                    else if (c == CH_B)
                    begin
                        data_pkt.bytes[0] = 8'h08;
                    end
                    else if (c == CH_F)
                    begin
                        data_pkt.bytes[0] = 8'h0c;
                    end
                    else if (c == CH_N)
                    begin
                        data_pkt.bytes[0] = 8'h0a;
                    end
                    else if (c == CH_R)
                    begin
                        data_pkt.bytes[0] = 8'h0d;
                    end
                    else if (c == CH_T)
                    begin
                        data_pkt.bytes[0] = 8'h09;
                    end
                    else if (c == CH_U)
                    begin
                        has_data   = 1'b0;
                        phase_next = PH_HEX1;
                        hex_next   = '0;
                        hcnt_next  = '0;
                    end
                    else
                    begin
                        has_data = 1'b0;
                        err      = 1'b1;
                    end
                end
                PH_HEX1, PH_HEX2:
                begin
                    if (!dig[4])
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        hex_next  = hex_new;
                        hcnt_next = hex_done ? 2'd0 : hcnt_reg + 2'd1;
                        if (hex_done)
                        begin
                            if (phase_reg == PH_HEX1)
                            begin
                                if (hex_new[15:10] == SUR_LO)
                                begin
                                    err = 1'b1;
                                end
                                else if (hex_new[15:10] == SUR_HI)
                                begin
                                    hsur_next  = hex_new[9:0];
                                    phase_next = PH_PAIR_BS;
                                end
                                else
                                begin
                                    has_data   = 1'b1;
                                    data_pkt   = utf8_enc({5'd0, hex_new});
                                    phase_next = PH_STR;
                                end
                            end
                            else if (hex_new[15:10] != SUR_LO)
                            begin
                                err = 1'b1;
                            end
                            else
                            begin
                                has_data   = 1'b1;
                                data_pkt   = utf8_enc(cp_pair);
                                phase_next = PH_STR;
                            end
                        end
                    end
                end
                PH_PAIR_BS:
                begin
                    if (c == CH_BSLASH)
                    begin
                        phase_next = PH_PAIR_U;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                PH_PAIR_U:
                begin
                    if (c == CH_U)
                    begin
                        phase_next = PH_HEX2;
                        hex_next   = '0;
                        hcnt_next  = '0;
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // string left open at end of input
        if (!err && !close && phase_next != PH_IDLE && in_ch.data.input_ends)
        begin
            err = 1'b1;
        end

        if (err || close)
        begin
            phase_next = PH_IDLE;
            hex_next   = '0;
            hcnt_next  = '0;
            hsur_next  = '0;
        end
    end

    always_comb
    begin
        push     = acc && (err || close || has_data);
        push_pkt = data_pkt;
        if (err || close)
        begin
            push_pkt      = '0;
            push_pkt.kind = err ? KIND_ERR : KIND_CLOSE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hex_reg   <= '0;
            hcnt_reg  <= '0;
            hsur_reg  <= '0;
        end
        else if (acc)
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            hcnt_reg  <= hcnt_next;
            hsur_reg  <= hsur_next;
        end
    end

endmodule

// ----- hw/rtl/jsu_fifo.sv -----
module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pkt_t push_pkt,
    input  logic pop,
    output pkt_t pop_pkt,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pkt_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_pkt = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

// ----- hw/rtl/jsu_back.sv -----
module jsu_back
    import jsu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  pkt_t          q_pkt,
    output logic          pop,
    jsu_stream_if.source  out_ch
);

    pkt_t       ent_reg;
    logic       have_reg;
    logic [1:0] idx_reg;

    logic take;
    logic at_last;
    logic fin;

    assign at_last = (idx_reg == ent_reg.last_idx);
    assign take    = have_reg && out_ch.ready;
    assign fin     = take && at_last;
    assign pop     = (!have_reg || fin) && !q_empty;

    assign out_ch.valid         = have_reg;
    assign out_ch.data.out_byte = ent_reg.bytes[idx_reg];
    assign out_ch.data.kind     = ent_reg.kind;
    assign out_ch.data.last     = at_last;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= q_pkt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (pop)
        begin
            have_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (fin)
        begin
            have_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && ent_reg.kind != KIND_DATA) |-> (at_last && idx_reg == 2'd0))
        else $error("close/error request spans more than one result");

    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        (fin && !q_empty) |=> (out_ch.valid && idx_reg == 2'd0))
        else $error("bubble between queued requests");
`endif

endmodule

// ----- hw/rtl/json_string_unescape_utf8_unit.sv -----
// JSON string unescape to UTF-8.
// Path: a result is written into the queue, then loaded into the back-end output register.
// Throughput: one input byte per cycle and, while out_ch is ready, one result per
//   cycle; 2..4 byte UTF-8 requests go out byte by byte; input stalls only on a full queue.
// Reset: rst_n is asynchronous, active low; parser goes idle and the queue empties.
module json_string_unescape_utf8_unit
    import jsu_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    jsu_stream_if.sink    in_ch,
    jsu_stream_if.source  out_ch
);

    // Front: runs the string parser, one byte per cycle while the queue is not
    // full, and turns each byte into at most one request (data bytes, close, or
    // error). Bytes that only advance the parser (backslash, hex digits) push nothing.
    //
    // Queue: decouples the parser from the output so a multi-byte UTF-8
    // request does not stop input until the queue is full.
    //
    // Back: unrolls each request into 1..4 results, marking the final one.

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    pkt_t q_push_pkt;
    pkt_t q_pop_pkt;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_full   (q_full),
        .push     (q_push),
        .push_pkt (q_push_pkt)
    );

    jsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_pkt (q_push_pkt),
        .pop      (q_pop),
        .pop_pkt  (q_pop_pkt),
        .full     (q_full),
        .empty    (q_empty)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pkt   (q_pop_pkt),
        .pop     (q_pop),
        .out_ch  (out_ch)
    );

endmodule
